// ----- rtl/frl_pkg.sv -----
// Shared types and constants for the firmware record loader.
// No dependencies; used by every module of the block.
package frl_pkg;

    localparam int unsigned POS_W  = 20;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned BYTE_W = 8;

    localparam logic [LEN_W-1:0] END_MARK = 16'h8001;

    typedef enum logic [0:0] {
        CFG_START_OFFSET = 1'b0,
        CFG_IMAGE_SIZE   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAIL  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_ADR_HI = 3'd3,
        PH_ADR_LO = 3'd4,
        PH_DATA   = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  load_address;
        logic [BYTE_W-1:0]  write_data;
        logic               chunk_end;
        logic               image_end;
    } frl_result_t;

endpackage

// ----- rtl/frl_parser.sv -----
// Record parser: holds the parse state and turns each accepted byte into at most one result.
// Depends on frl_pkg.
module frl_parser #(
    parameter int unsigned MAX_RECORD_BYTES = 1024,
    parameter int unsigned CHUNK_BYTES      = 50
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         beat,
    input  logic [frl_pkg::BYTE_W-1:0]   image_byte,
    input  logic [frl_pkg::POS_W-1:0]    start_offset,
    input  logic [frl_pkg::POS_W-1:0]    image_size,
    output logic                         res_valid,
    output frl_pkg::frl_result_t         res
);
    import frl_pkg::*;

    localparam int unsigned BL_W = (MAX_RECORD_BYTES > 2) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam int unsigned CC_W = $clog2(CHUNK_BYTES + 1);
    localparam logic [LEN_W:0]  MAX_LEN   = (LEN_W+1)'(MAX_RECORD_BYTES);
    localparam logic [CC_W-1:0] CHUNK_TOP = CC_W'(CHUNK_BYTES);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BL_W-1:0]    left_reg, left_next;
    logic [CC_W-1:0]    count_reg, count_next;

    phase_t             eff_phase;
    logic               last;
    kind_t              skip_kind;
    logic [POS_W:0]     rec_end;
    logic [CC_W-1:0]    count_inc;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind   = KIND_WRITE;

        last      = ({1'b0, pos_reg} + (POS_W+1)'(1)) == {1'b0, image_size};
        skip_kind = (start_offset > image_size) ? KIND_FAIL : KIND_DONE;
        rec_end   = {1'b0, pos_reg} + (POS_W+1)'(1) + (POS_W+1)'(len_reg);
        count_inc = count_reg + CC_W'(1);
        eff_phase = (phase_reg == PH_SKIP && pos_reg >= start_offset) ? PH_LEN_HI : phase_reg;

        if (beat && phase_reg != PH_DONE)
        begin
            if (pos_reg >= image_size)
            begin
                res_valid  = 1'b1;
                phase_next = PH_DONE;
                if (phase_reg == PH_DATA)
                    res.kind = KIND_FAIL;
                else if (phase_reg == PH_SKIP)
                    res.kind = skip_kind;
                else
                    res.kind = KIND_DONE;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                unique case (eff_phase)
                    PH_SKIP:
                    begin
                        if (last)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = skip_kind;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        len_next[15:8] = image_byte;
                        phase_next     = last ? PH_DONE : PH_LEN_LO;
                        res_valid      = last;
                        res.kind       = KIND_DONE;
                    end
                    PH_LEN_LO:
                    begin
                        len_next[7:0] = image_byte;
                        phase_next    = last ? PH_DONE : PH_ADR_HI;
                        res_valid     = last;
                        res.kind      = KIND_DONE;
                    end
                    PH_ADR_HI:
                    begin
                        addr_next[15:8] = image_byte;
                        phase_next      = last ? PH_DONE : PH_ADR_LO;
                        res_valid       = last;
                        res.kind        = KIND_DONE;
                    end
                    PH_ADR_LO:
                    begin
                        addr_next[7:0] = image_byte;
                        priority if (len_reg == END_MARK)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_DONE;
                            phase_next = PH_DONE;
                        end
                        else if (len_reg == '0)
                        begin
                            phase_next = last ? PH_DONE : PH_LEN_HI;
                            res_valid  = last;
                            res.kind   = KIND_DONE;
                        end
                        else if ({1'b0, len_reg} >= MAX_LEN || rec_end > {1'b0, image_size})
                        begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_FAIL;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            left_next  = len_reg[BL_W-1:0];
                            count_next = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_WRITE;
                        res.load_address = addr_reg;
                        res.write_data   = image_byte;
                        res.chunk_end    = (count_inc >= CHUNK_TOP) || (left_reg == BL_W'(1));
                        res.image_end    = last;
                        addr_next        = addr_reg + ADDR_W'(1);
                        left_next        = left_reg - BL_W'(1);
                        count_next       = res.chunk_end ? '0 : count_inc;
                        if (last)
                            phase_next = PH_DONE;
                        else if (left_reg == BL_W'(1))
                            phase_next = PH_LEN_HI;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            pos_reg   <= '0;
            len_reg   <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/frl_out_stage.sv -----
// Result register between the parser and the output channel.
// Depends on frl_pkg.
module frl_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat,
    input  logic                  res_valid,
    input  frl_pkg::frl_result_t  res,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  slot_free,
    output frl_pkg::frl_result_t  out_res
);
    import frl_pkg::*;

    logic         valid_reg, valid_next;
    frl_result_t  res_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_comb
    begin
        if (beat)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (beat && res_valid)
            res_reg <= res;
    end

endmodule

// ----- rtl/firmware_record_loader.sv -----
// Top level of the firmware record loader: configuration registers, parser and result register.
// Depends on frl_pkg, frl_parser and frl_out_stage.

// The block takes one image byte per beat and can accept a beat in every clock cycle. Each byte
// updates the parse state in the cycle it is accepted, and any result it causes (a memory write,
// load finished or load failed) appears in the output register on the following cycle. A new
// byte is taken whenever the output register is empty or is being emptied in the same cycle, so
// a stalled output holds the input back by exactly one result. Configuration writes are always
// accepted and should only be made while the block is idle. Once a load has ended, further
// bytes are accepted and discarded until reset.
module firmware_record_loader #(
    parameter int unsigned MAX_RECORD_BYTES = 1024,
    parameter int unsigned CHUNK_BYTES      = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  image_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] load_address,
    output logic [7:0]  write_data,
    output logic        chunk_end,
    output logic        image_end
);
    import frl_pkg::*;

    logic [POS_W-1:0]  start_offset_reg;
    logic [POS_W-1:0]  image_size_reg;
    logic              beat;
    logic              slot_free;
    logic              res_valid;
    frl_result_t       res;
    frl_result_t       out_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = slot_free;
    assign beat      = in_valid && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
            image_size_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_OFFSET: start_offset_reg <= cfg_data;
                CFG_IMAGE_SIZE:   image_size_reg   <= cfg_data;
                default:          start_offset_reg <= start_offset_reg;
            endcase
        end
    end

    frl_parser #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
        .CHUNK_BYTES      (CHUNK_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .image_byte   (image_byte),
        .start_offset (start_offset_reg),
        .image_size   (image_size_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    frl_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .slot_free (slot_free),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign load_address = out_res.load_address;
    assign write_data   = out_res.write_data;
    assign chunk_end    = out_res.chunk_end;
    assign image_end    = out_res.image_end;

    a_image_end_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> kind == KIND_WRITE)
        else $error("image end flagged on a non-write result");

    a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_WRITE |->
            load_address == '0 && write_data == '0 && !chunk_end && !image_end)
        else $error("status result carries write fields");

    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind != KIND_WRITE || image_end) |=> !out_valid)
        else $error("result given after the load ended");

endmodule
